@@ hdl/wid_pkg.sv @@
// ----------------------------------------------------------------------------
// wid_pkg
// Types and constants shared by the windowed interval downtime block.
// ----------------------------------------------------------------------------
package wid_pkg;

  localparam int unsigned LINK_W    = 3;
  localparam int unsigned DAYS_W    = 11;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned DOWN_W    = 27;
  localparam int unsigned UP_W      = 14;
  localparam int unsigned SPAN_W    = 28;
  localparam int unsigned NUM_W     = UP_W + SPAN_W;
  localparam int unsigned DIV_STEPS = UP_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [16:0]       SECS_PER_DAY = 17'd86400;
  localparam logic [DOWN_W-1:0] DOWN_MAX     = {DOWN_W{1'b1}};
  localparam logic [UP_W-1:0]   FULL_UPTIME  = 14'd10000;

  typedef enum logic {
    OP_EVENT = 1'b0,
    OP_CLOSE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_TARGET_LINK = 2'd0,
    CFG_WINDOW_DAYS = 2'd1,
    CFG_NOW_TIME    = 2'd2,
    CFG_CLOCK_VALID = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [LINK_W-1:0] target_link;
    logic [SPAN_W-1:0] span;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] win_start;
    logic              win_ok;
  } win_cfg_t;

  typedef struct packed {
    logic              close;
    logic              add;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
  } q_entry_t;

  typedef enum logic [1:0] {
    B_RUN,
    B_MUL,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

@@ hdl/wid_ifs.sv @@
// ----------------------------------------------------------------------------
// wid_in_if / wid_out_if
// Valid/ready channels for input items and results.
// ----------------------------------------------------------------------------
interface wid_in_if import wid_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [LINK_W-1:0] event_link;
  logic [TIME_W-1:0] event_start;
  logic [TIME_W-1:0] event_end;
  logic              active_failure;
  logic [TIME_W-1:0] active_start;

  modport source (
    output valid, op, event_link, event_start, event_end, active_failure, active_start,
    input  ready
  );
  modport sink (
    input  valid, op, event_link, event_start, event_end, active_failure, active_start,
    output ready
  );
endinterface

interface wid_out_if import wid_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DOWN_W-1:0] downtime_seconds;
  logic [UP_W-1:0]   uptime_hundredths;

  modport source (
    output valid, downtime_seconds, uptime_hundredths,
    input  ready
  );
  modport sink (
    input  valid, downtime_seconds, uptime_hundredths,
    output ready
  );
endinterface

@@ hdl/wid_front.sv @@
// ----------------------------------------------------------------------------
// wid_front
// Accepts items, filters them and clips intervals to the window.
// ----------------------------------------------------------------------------
module wid_front import wid_pkg::*; #(
  parameter int unsigned LINK_COUNT = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  win_cfg_t cfg,
  wid_in_if.sink   in_ch,
  output logic     q_push,
  output q_entry_t q_data,
  input  logic     q_ready
);

  logic              stg_v_r;
  logic              stg_op_r;
  logic [LINK_W-1:0] stg_link_r;
  logic [TIME_W-1:0] stg_start_r;
  logic [TIME_W-1:0] stg_end_r;
  logic              stg_act_r;
  logic [TIME_W-1:0] stg_act_start_r;

  logic              is_close;
  logic              keep;
  logic [TIME_W-1:0] raw_lo;
  logic [TIME_W-1:0] raw_hi;
  logic [TIME_W-1:0] clip_lo;
  logic [TIME_W-1:0] clip_hi;
  logic              need_push;
  logic              stg_done;
  logic              in_xfer;

  always_comb begin
    is_close = (stg_op_r == OP_CLOSE);
    if (is_close) begin
      raw_lo = stg_act_start_r;
      raw_hi = cfg.now;
      keep   = cfg.win_ok && stg_act_r && (stg_act_start_r != '0);
    end else begin
      raw_lo = stg_start_r;
      raw_hi = stg_end_r;
      keep   = cfg.win_ok && (stg_start_r != '0) && (stg_link_r == cfg.target_link) &&
               (32'(stg_link_r) < LINK_COUNT);
    end
    clip_lo   = (raw_lo < cfg.win_start) ? cfg.win_start : raw_lo;
    clip_hi   = (raw_hi > cfg.now) ? cfg.now : raw_hi;
    q_data.close = is_close;
    q_data.add   = keep && (clip_hi > clip_lo);
    q_data.lo    = clip_lo;
    q_data.hi    = clip_hi;
    need_push = is_close || q_data.add;
    stg_done  = !need_push || q_ready;
  end

  assign q_push      = stg_v_r && need_push && q_ready;
  assign in_ch.ready = !stg_v_r || stg_done;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_xfer) begin
      stg_v_r <= 1'b1;
    end else if (stg_done) begin
      stg_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stg_op_r        <= in_ch.op;
      stg_link_r      <= in_ch.event_link;
      stg_start_r     <= in_ch.event_start;
      stg_end_r       <= in_ch.event_end;
      stg_act_r       <= in_ch.active_failure;
      stg_act_start_r <= in_ch.active_start;
    end
  end

endmodule

@@ hdl/wid_fifo.sv @@
// ----------------------------------------------------------------------------
// wid_fifo
// Short queue of clipped intervals between front and back.
// ----------------------------------------------------------------------------
module wid_fifo import wid_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t din,
  output logic     ready,
  input  logic     pop,
  output logic     valid,
  output q_entry_t dout
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  q_entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               do_push;
  logic               do_pop;

  assign ready   = (cnt_r != CNT_W'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

@@ hdl/wid_back.sv @@
// ----------------------------------------------------------------------------
// wid_back
// Union accumulation of clipped intervals; uptime by restoring division.
// ----------------------------------------------------------------------------
module wid_back import wid_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  win_cfg_t cfg,
  input  logic     q_valid,
  input  q_entry_t q_head,
  output logic     q_pop,
  wid_out_if.source out_ch
);

  back_state_t       state_r;
  back_state_t       state_nxt;
  logic [DOWN_W-1:0] down_r;
  logic [TIME_W-1:0] lat_r;
  logic [DOWN_W-1:0] dsnap_r;
  logic [NUM_W-1:0]  rem_r;
  logic [NUM_W-1:0]  dsh_r;
  logic [UP_W-1:0]   quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              out_valid_r;
  logic [DOWN_W-1:0] out_down_r;
  logic [UP_W-1:0]   out_up_r;

  logic              out_free;
  logic              out_load;
  logic              special;
  logic [UP_W-1:0]   special_val;
  logic [SPAN_W-1:0] diff;
  logic [TIME_W-1:0] le;
  logic [TIME_W-1:0] base;
  logic [TIME_W-1:0] gain;
  logic [DOWN_W:0]   sum;
  logic [DOWN_W-1:0] sum_sat;
  logic [DOWN_W-1:0] down_upd;
  logic [TIME_W-1:0] lat_upd;
  logic              rem_ge;

  // union add
  always_comb begin
    le       = (lat_r > cfg.win_start) ? lat_r : cfg.win_start;
    base     = (q_head.lo > le) ? q_head.lo : le;
    gain     = (q_head.hi > base) ? q_head.hi - base : '0;
    sum      = (DOWN_W + 1)'(down_r) + (DOWN_W + 1)'(gain);
    sum_sat  = (sum > (DOWN_W + 1)'(DOWN_MAX)) ? DOWN_MAX : sum[DOWN_W-1:0];
    down_upd = q_head.add ? sum_sat : down_r;
    lat_upd  = (q_head.hi > le) ? q_head.hi : le;
  end

  always_comb begin
    special     = 1'b0;
    special_val = '0;
    if (cfg.span == '0) begin
      special     = 1'b1;
      special_val = FULL_UPTIME;
    end else if (SPAN_W'(dsnap_r) > cfg.span) begin
      special     = 1'b1;
    end
    diff   = cfg.span - SPAN_W'(dsnap_r);
    rem_ge = (rem_r >= dsh_r);
  end

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_RUN:  if (q_valid && q_head.close) state_nxt = B_MUL;
      B_MUL:  state_nxt = special ? B_DONE : B_DIV;
      B_DIV:  if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = B_DONE;
      B_DONE: if (out_free) state_nxt = B_RUN;
      default: state_nxt = B_RUN;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      B_RUN:  q_pop = q_valid;
      B_DONE: out_load = out_free;
      default: begin
        q_pop    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_RUN;
      down_r      <= '0;
      lat_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        if (q_head.close) begin
          down_r <= '0;
          lat_r  <= '0;
        end else if (q_head.add) begin
          down_r <= sum_sat;
          lat_r  <= lat_upd;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.close) begin
      dsnap_r <= cfg.win_ok ? down_upd : '0;
    end
    case (state_r)
      B_MUL: begin
        rem_r <= NUM_W'(FULL_UPTIME) * NUM_W'(diff);
        dsh_r <= NUM_W'({cfg.span, {(DIV_STEPS - 1){1'b0}}});
        quo_r <= special_val;
        cnt_r <= '0;
      end
      B_DIV: begin
        if (rem_ge) begin
          rem_r <= rem_r - dsh_r;
        end
        quo_r <= {quo_r[UP_W-2:0], rem_ge};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_down_r <= dsnap_r;
      out_up_r   <= quo_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.downtime_seconds  = out_down_r;
  assign out_ch.uptime_hundredths = out_up_r;

endmodule

@@ hdl/windowed_interval_downtime.sv @@
// ----------------------------------------------------------------------------
// windowed_interval_downtime
// Event records: one per cycle while the queue has room, through the staging
// register and the queue into the sum. Close item: multiply, divide and done
// states, then output register; no division when none is needed (zero period
// or downtime past it). Later items wait for the 14-step restoring divider.
// Synchronous active-low reset restores register defaults and clears the sum.
// ----------------------------------------------------------------------------
module windowed_interval_downtime import wid_pkg::*; #(
  parameter int unsigned LINK_COUNT  = 8,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_wdata,
  wid_in_if.sink      in_ch,
  wid_out_if.source   out_ch
);

  logic [LINK_W-1:0] target_link_r;
  logic [SPAN_W-1:0] span_r;
  logic [TIME_W-1:0] now_r;
  logic              clock_valid_r;
  logic [TIME_W-1:0] ws_r;
  logic              ok_r;

  win_cfg_t cfg;
  logic     q_push;
  logic     q_ready;
  logic     q_valid;
  logic     q_pop;
  q_entry_t q_in;
  q_entry_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_link_r <= '0;
      span_r        <= SPAN_W'(SECS_PER_DAY);
      now_r         <= '0;
      clock_valid_r <= 1'b0;
      ws_r          <= '0;
      ok_r          <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_TARGET_LINK: target_link_r <= cfg_wdata[LINK_W-1:0];
          CFG_WINDOW_DAYS: span_r <= SPAN_W'(cfg_wdata[DAYS_W-1:0]) * SPAN_W'(SECS_PER_DAY);
          CFG_NOW_TIME:    now_r <= cfg_wdata[TIME_W-1:0];
          CFG_CLOCK_VALID: clock_valid_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      ws_r <= now_r - TIME_W'(span_r);
      ok_r <= clock_valid_r && (TIME_W'(span_r) < now_r);
    end
  end

  assign cfg.target_link = target_link_r;
  assign cfg.span        = span_r;
  assign cfg.now         = now_r;
  assign cfg.win_start   = ws_r;
  assign cfg.win_ok      = ok_r;

  wid_front #(
    .LINK_COUNT (LINK_COUNT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .q_push  (q_push),
    .q_data  (q_in),
    .q_ready (q_ready)
  );

  wid_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .ready (q_ready),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_head)
  );

  wid_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  a_up_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.uptime_hundredths <= FULL_UPTIME)
    else $error("uptime above full scale");

  a_zero_down_full_up: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && span_r != '0 && out_ch.downtime_seconds == '0)
      |-> out_ch.uptime_hundredths == FULL_UPTIME)
    else $error("no downtime but uptime not full");

  a_invalid_clock: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !clock_valid_r) |-> out_ch.downtime_seconds == '0)
    else $error("downtime reported with invalid clock");

endmodule

@@ bench/wid_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wid_checker
// Watches the configuration port and both channels of the windowed interval
// downtime block. Keeps its own copy of the registers and of the union sum,
// predicts a downtime report for every close transfer and compares each
// report transfer with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module wid_checker import wid_pkg::*; #(
  parameter int unsigned LINK_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_wdata,
  wid_in_if           in_ch,
  wid_out_if          out_ch,
  output int          mismatches,
  output int          reports_due,
  output int          transfers,
  output int          reports
);

  typedef struct packed {
    logic [DOWN_W-1:0] down;
    logic [UP_W-1:0]   up;
  } report_t;

  logic [LINK_W-1:0] link_sel;
  logic [DAYS_W-1:0] days_sel;
  logic [TIME_W-1:0] now_sel;
  logic              clk_ok;

  logic [DOWN_W-1:0] acc_down;
  logic [TIME_W-1:0] reach_end;

  report_t           reports_q[$];

  function automatic logic window_open(output logic [63:0] ws);
    logic [63:0] span;
    span = 64'(days_sel) * 64'(SECS_PER_DAY);
    ws   = 64'd0;
    if (!clk_ok || span >= 64'(now_sel)) return 1'b0;
    ws = 64'(now_sel) - span;
    return 1'b1;
  endfunction

  // adds the part of [a, b) inside the window that lies past the furthest end
  function automatic void fold_interval(logic [63:0] a, logic [63:0] b, logic [63:0] ws);
    logic [63:0] le, lo, hi, add, sum;
    le  = (64'(reach_end) > ws) ? 64'(reach_end) : ws;
    lo  = (a < ws) ? ws : a;
    hi  = (b > 64'(now_sel)) ? 64'(now_sel) : b;
    add = 64'd0;
    if (hi <= lo) return;
    if (lo > le) add = hi - lo;
    else if (hi > le) add = hi - le;
    sum      = 64'(acc_down) + add;
    acc_down = (sum > 64'(DOWN_MAX)) ? DOWN_MAX : sum[DOWN_W-1:0];
    if (hi > le) le = hi;
    reach_end = le[TIME_W-1:0];
  endfunction

  task automatic take_item();
    logic [63:0] ws, period, down, up;
    logic        ok;
    report_t     r;
    ok = window_open(ws);
    if (op_t'(in_ch.op) == OP_EVENT) begin
      if (ok && in_ch.event_start != '0 && in_ch.event_link == link_sel &&
          32'(in_ch.event_link) < LINK_COUNT && 32'(link_sel) < LINK_COUNT)
        fold_interval(64'(in_ch.event_start), 64'(in_ch.event_end), ws);
    end else begin
      if (ok && in_ch.active_failure && in_ch.active_start != '0)
        fold_interval(64'(in_ch.active_start), 64'(now_sel), ws);
      down   = ok ? 64'(acc_down) : 64'd0;
      period = 64'(days_sel) * 64'(SECS_PER_DAY);
      if (period == 64'd0) up = 64'(FULL_UPTIME);
      else if (down > period) up = 64'd0;
      else up = (64'(FULL_UPTIME) * (period - down)) / period;
      r.down = down[DOWN_W-1:0];
      r.up   = up[UP_W-1:0];
      reports_q.push_back(r);
      acc_down  = '0;
      reach_end = '0;
    end
  endtask

  always @(posedge clk) begin
    report_t want;
    if (!rst_n) begin
      link_sel   = '0;
      days_sel   = DAYS_W'(1);
      now_sel    = '0;
      clk_ok     = 1'b0;
      acc_down   = '0;
      reach_end  = '0;
      mismatches = 0;
      transfers  = 0;
      reports    = 0;
      reports_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_TARGET_LINK: link_sel = cfg_wdata[LINK_W-1:0];
          CFG_WINDOW_DAYS: days_sel = cfg_wdata[DAYS_W-1:0];
          CFG_NOW_TIME:    now_sel  = cfg_wdata[TIME_W-1:0];
          CFG_CLOCK_VALID: clk_ok   = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        transfers++;
        take_item();
      end
      if (out_ch.valid && out_ch.ready) begin
        reports++;
        if (reports_q.size() == 0) begin
          $error("unexpected report: downtime_seconds %0d uptime_hundredths %0d",
                 out_ch.downtime_seconds, out_ch.uptime_hundredths);
          mismatches++;
        end else begin
          want = reports_q.pop_front();
          if (out_ch.downtime_seconds !== want.down) begin
            $error("downtime_seconds: expected %0d, got %0d", want.down,
                   out_ch.downtime_seconds);
            mismatches++;
          end
          if (out_ch.uptime_hundredths !== want.up) begin
            $error("uptime_hundredths: expected %0d, got %0d", want.up,
                   out_ch.uptime_hundredths);
            mismatches++;
          end
        end
      end
    end
    reports_due = reports_q.size();
  end

endmodule

@@ bench/windowed_interval_downtime_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_interval_downtime_test
// Drives the windowed interval downtime block: a directed pass over window
// edges, skipped events, overlaps, invalid clock, zero-length window and sum
// saturation, then random phases of ordered failure logs closed by reports,
// under bursty input and a stalling receiver. wid_checker does the scoring.
// ----------------------------------------------------------------------------
module windowed_interval_downtime_test import wid_pkg::*; ();

  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS   = 715;
  localparam int SETTLE_CYCLES  = 48;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_BLOCK
  } rx_mode_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_wdata;

  wid_in_if  in_ch ();
  wid_out_if out_ch ();

  int chk_mismatches;
  int reports_due;
  int chk_transfers;
  int chk_reports;

  int items_sent = 0;
  int settings   = 0;
  int burst_left = 0;

  logic [LINK_W-1:0] cur_link;
  logic [DAYS_W-1:0] cur_days;
  logic [TIME_W-1:0] cur_now;

  rx_mode_t rx_mode      = RX_OPEN;
  int       stretch_left = 0;

  windowed_interval_downtime dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  wid_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (chk_mismatches),
    .reports_due (reports_due),
    .transfers   (chk_transfers),
    .reports     (chk_reports)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(negedge clk) begin
    if (stretch_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      stretch_left = $urandom_range(16, 160);
    end
    stretch_left--;
    case (rx_mode)
      RX_OPEN:   out_ch.ready <= 1'b1;
      RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default:   out_ch.ready <= ((stretch_left % 32) < 3);
    endcase
  end

  function automatic logic [TIME_W-1:0] to_time(longint x);
    if (x < 0) return '0;
    if (x > longint'(32'hFFFF_FFFF)) return '1;
    return x[TIME_W-1:0];
  endfunction

  task automatic push_item(op_t op, logic [LINK_W-1:0] link, logic [TIME_W-1:0] ev_start,
                           logic [TIME_W-1:0] ev_end, logic act,
                           logic [TIME_W-1:0] act_start);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid          <= 1'b1;
    in_ch.op             <= op;
    in_ch.event_link     <= link;
    in_ch.event_start    <= ev_start;
    in_ch.event_end      <= ev_end;
    in_ch.active_failure <= act;
    in_ch.active_start   <= act_start;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic push_event(logic [LINK_W-1:0] link, logic [TIME_W-1:0] s,
                            logic [TIME_W-1:0] e);
    push_item(OP_EVENT, link, s, e, 1'($urandom_range(0, 1)), $urandom);
  endtask

  task automatic push_close(logic act, logic [TIME_W-1:0] act_at);
    push_item(OP_CLOSE, 3'($urandom_range(0, 7)), $urandom, $urandom, act, act_at);
  endtask

  // drain outstanding reports and let in-flight events land before a write
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (reports_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_window(logic [LINK_W-1:0] link, logic [DAYS_W-1:0] days,
                            logic [TIME_W-1:0] now, logic valid_clk);
    cur_link = link;
    cur_days = days;
    cur_now  = now;
    write_reg(CFG_TARGET_LINK, 32'(link));
    write_reg(CFG_WINDOW_DAYS, 32'(days));
    write_reg(CFG_NOW_TIME, now);
    write_reg(CFG_CLOCK_VALID, 32'(valid_clk));
    settings++;
  endtask

  task automatic pick_window();
    int                r;
    logic [DAYS_W-1:0] days;
    logic [TIME_W-1:0] now;
    longint            span;
    r = $urandom_range(0, 9);
    if (r < 6) days = DAYS_W'($urandom_range(1, 7));
    else if (r < 8) days = DAYS_W'($urandom_range(1, 1024));
    else days = DAYS_W'(1024);
    span = longint'(days) * 86400;
    r = $urandom_range(0, 7);
    if (r == 0) now = $urandom;
    else if (r == 1) now = '1;
    else now = to_time(span + $urandom_range(1, 32'h7FFF_FFFF));
    set_window(3'($urandom_range(0, 7)), days, now, ($urandom_range(0, 7) != 0));
  endtask

  // log-ordered failures around the window, with some noise mixed in
  task automatic stream_events(int count);
    longint            span, ws, step, cursor, s, e;
    int                kind;
    logic [LINK_W-1:0] link;
    span = longint'(cur_days) * 86400;
    ws   = longint'(cur_now) - span;
    if (ws < 1) ws = 1;
    step   = span / 6 + 1;
    cursor = ws - step;
    for (int k = 0; k < count; k++) begin
      cursor += $urandom_range(0, int'(step));
      s    = cursor;
      e    = s + $urandom_range(0, int'(step));
      link = cur_link;
      kind = $urandom_range(0, 11);
      case (kind)
        0: link = cur_link + 3'($urandom_range(1, 7));
        1: s = 0;
        2: begin
          s = $urandom;
          e = $urandom;
        end
        3: e = s - $urandom_range(1, int'(step));
        4: s = s - $urandom_range(0, 2 * int'(step));
        default: ;
      endcase
      push_event(link, to_time(s), to_time(e));
    end
  endtask

  task automatic close_report();
    longint            span, ws;
    logic [TIME_W-1:0] act_at;
    span = longint'(cur_days) * 86400;
    ws   = longint'(cur_now) - span;
    case ($urandom_range(0, 2))
      0:       act_at = '0;
      1:       act_at = to_time(ws + $urandom_range(0, int'(span)));
      default: act_at = $urandom;
    endcase
    push_close(1'($urandom_range(0, 1)), act_at);
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = '0;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.op             = OP_EVENT;
    in_ch.event_link     = '0;
    in_ch.event_start    = '0;
    in_ch.event_end      = '0;
    in_ch.active_failure = 1'b0;
    in_ch.active_start   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    settle();

    // one-day window ending at 1000000: skips, clipping, overlaps, closes
    set_window(3, 1, 1_000_000, 1'b1);
    push_event(5, 920_000, 930_000);
    push_event(3, 0, 950_000);
    push_event(3, 100, 200);
    push_event(3, 900_000, 920_000);
    push_event(3, 910_000, 930_000);
    push_event(3, 921_000, 925_000);
    push_event(3, 940_000, 950_000);
    push_event(3, 990_000, '1);
    push_event(3, 960_000, 950_000);
    push_close(1'b1, 995_000);
    push_close(1'b0, 995_000);
    push_close(1'b1, 0);
    push_close(1'b1, 999_000);

    // clock not synchronised
    settle();
    set_window(3, 1, 1_000_000, 1'b0);
    push_event(3, 920_000, 930_000);
    push_close(1'b1, 990_000);

    // window start lands on zero
    settle();
    set_window(3, 1, 86_400, 1'b1);
    push_event(3, 100, 200);
    push_close(1'b1, 50);

    // zero-length window
    settle();
    set_window(7, 0, 500, 1'b1);
    push_event(7, 1, 1000);
    push_close(1'b1, 100);

    // widest window at the top of time
    settle();
    set_window(0, 1024, '1, 1'b1);
    push_event(0, '1, '1);
    push_event(0, 1, '1);
    push_close(1'b1, '1);

    // window moves on between events: sum saturates and exceeds the period
    settle();
    set_window(0, 1024, 100_000_000, 1'b1);
    push_event(0, 1, '1);
    settle();
    set_window(0, 1024, 200_000_000, 1'b1);
    push_event(0, 1, '1);
    push_close(1'b0, 0);

    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      settle();
      pick_window();
      repeat ($urandom_range(1, 4)) begin
        stream_events($urandom_range(0, 12));
        close_report();
      end
      if ($urandom_range(0, 4) == 0) stream_events($urandom_range(1, 6));
    end

    settle();
    $display("Covered %0d input transfers, %0d downtime reports, %0d register settings.",
             chk_transfers, chk_reports, settings);
    if (chk_mismatches == 0 && reports_due == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
